[rtl/error_diffusion_halftoner_defines.svh]
// ----------------------------------------------------------------------------
// Error diffusion halftoner assertion macros
// Shared wrappers for concurrent assertions on the halftoner clock.
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_HALFTONER_DEFINES_SVH
`define ERROR_DIFFUSION_HALFTONER_DEFINES_SVH

// check outside reset
`define EDH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// check on every edge, reset included
`define EDH_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/edh_pkg.sv]
// ----------------------------------------------------------------------------
// Error diffusion halftoner package
// Shared types, constants and arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package edh_pkg;

   localparam int GRAY_W           = 8;
   localparam int REQ_TDATA_W      = 8;
   localparam int RSP_TDATA_W      = 8;
   localparam int LINE_WIDTH_W     = 12;
   localparam int LINE_WIDTH_RESET = 2048;
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = LINE_WIDTH_W;
   localparam int ERR_W            = 8;
   localparam int CARRY_W          = 7;
   localparam int RSP_DEPTH        = 3;
   localparam int RSP_PTR_W        = 2;
   localparam int RSP_OCC_W        = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_OUTPUT = 1'b1;

   typedef logic signed [ERR_W-1:0]   err_type;
   typedef logic signed [CARRY_W-1:0] carry_type;
   typedef logic signed [11:0]        prod_type;

   typedef struct packed {
      logic pixel_bit;
      logic line_end;
   } rsp_item_type;

   function automatic logic [GRAY_W-1:0] clamp_add(logic [GRAY_W-1:0] lvl, err_type e);
      logic signed [9:0] s;
      s = $signed({2'b00, lvl}) + $signed({{2{e[ERR_W-1]}}, e});
      if (s >= 10'sd255) begin
         return 8'd255;
      end else if (s <= 10'sd0) begin
         return 8'd0;
      end
      return s[7:0];
   endfunction

   // divide by 16, truncating toward zero
   function automatic err_type div16(prod_type x);
      prod_type t;
      t = x[11] ? x + 12'sd15 : x;
      return t[11:4];
   endfunction

endpackage

`default_nettype wire

[rtl/error_diffusion_halftoner.sv]
// ----------------------------------------------------------------------------
// Error diffusion halftoner
// Turns 8-bit gray pixels in raster order into one bilevel bit per pixel
// with Floyd-Steinberg error diffusion. The block takes one pixel per clock
// while the output queue has room and gives one result per pixel. The pixel
// and its registered error line read feed the diffusion stage, which does
// correction, threshold and error split and fills the queue. The line width
// is fixed by the first pixel after reset; later width writes are ignored.
// No clearing pass follows reset: a fill count marks which columns of the
// error line have been written, and columns beyond it read as zero error. A
// three-entry output queue lets input go on while results wait to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module error_diffusion_halftoner #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [7:0] gray
   input  wire logic [edh_pkg::REQ_TDATA_W-1:0]      req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [0] pixel_bit, [7:1] zero
   output logic      [edh_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_we,
   input  wire logic [edh_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [edh_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import edh_pkg::*;

   localparam int CW          = $clog2(MAX_WIDTH);
   localparam int WW          = (CW + 1 > LINE_WIDTH_W) ? CW + 1 : LINE_WIDTH_W;
   localparam int RESET_WIDTH = (MAX_WIDTH < LINE_WIDTH_RESET) ? MAX_WIDTH : LINE_WIDTH_RESET;

   // configuration
   logic            started_ff;
   logic [CW-1:0]   width_last_ff;
   logic [CW-1:0]   width_last_in;
   logic            invert_ff;
   logic [WW-1:0]   lw_ext;
   logic [WW-1:0]   lw_m1;

   // issue stage
   logic            accept;
   logic [CW-1:0]   column_ff;
   logic            last_a;

   // diffusion stage
   logic               valid_b_ff;
   logic [CW-1:0]      col_b_ff;
   logic               last_b_ff;
   logic [GRAY_W-1:0]  gray_b_ff;
   logic               fwd_hit_ff;
   err_type            fwd_data_ff;
   logic               rd_zero_ff;
   logic [CW:0]        fill_ff;
   carry_type          carry_ff;
   err_type            acc_left_ff;
   err_type            acc_here_ff;
   logic               pend_valid_ff;
   logic [CW-1:0]      pend_addr_ff;
   err_type            pend_data_ff;

   logic [ERR_W-1:0]   ram_rd_data;
   err_type            line_err;
   logic [GRAY_W-1:0]  lvl1;
   logic [GRAY_W-1:0]  lvl2;
   logic               bit_b;
   err_type            err_b;
   prod_type           e12;
   err_type            d1;
   err_type            d3;
   err_type            d5;
   err_type            d7;
   err_type            acc_left_in;
   logic               w1_valid;
   err_type            w1_data;

   logic               ram_we;
   logic [CW-1:0]      ram_wa;
   err_type            ram_wd;

   // output queue
   rsp_item_type       fifo_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_OCC_W-1:0] occ_ff;
   logic               push;
   logic               pop;
   rsp_item_type       head;
   rsp_item_type       rsp_in;

   // ---------------------------------------------------------------- config
   always_comb begin
      lw_ext = WW'(csr_wdata);
      lw_m1  = lw_ext - WW'(1);
      if (lw_ext == '0) begin
         width_last_in = '0;
      end else if (lw_ext > WW'(MAX_WIDTH)) begin
         width_last_in = CW'(MAX_WIDTH - 1);
      end else begin
         width_last_in = lw_m1[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff <= CW'(RESET_WIDTH - 1);
         invert_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINE_WIDTH: begin
               if (!started_ff) begin
                  width_last_ff <= width_last_in;
               end
            end
            CSR_INVERT_OUTPUT: begin
               invert_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // ----------------------------------------------------------------- issue
   assign req_tready = !reset && (({1'b0, occ_ff} + 3'(valid_b_ff)) < 3'(RSP_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign last_a     = (column_ff == width_last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         column_ff  <= '0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= accept;
         if (accept) begin
            started_ff <= 1'b1;
            column_ff  <= last_a ? '0 : column_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_b_ff    <= column_ff;
         last_b_ff   <= last_a;
         gray_b_ff   <= req_tdata[GRAY_W-1:0];
         fwd_hit_ff  <= ram_we && (ram_wa == column_ff);
         fwd_data_ff <= ram_wd;
         rd_zero_ff  <= ({1'b0, column_ff} >= fill_ff);
      end
   end

   edh_ram #(
      .WIDTH (ERR_W),
      .DEPTH (MAX_WIDTH)
   ) u_error_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (accept),
      .rd_addr (column_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------- diffusion
   always_comb begin
      if (pend_valid_ff && (pend_addr_ff == col_b_ff)) begin
         line_err = pend_data_ff;
      end else if (fwd_hit_ff) begin
         line_err = fwd_data_ff;
      end else if (rd_zero_ff) begin
         line_err = '0;
      end else begin
         line_err = $signed(ram_rd_data);
      end

      if (gray_b_ff == 8'd0 || gray_b_ff == 8'd255) begin
         lvl1 = gray_b_ff;
      end else begin
         lvl1 = clamp_add(gray_b_ff, line_err);
      end
      if (lvl1 == 8'd0 || lvl1 == 8'd255) begin
         lvl2 = lvl1;
      end else begin
         lvl2 = clamp_add(lvl1, {carry_ff[CARRY_W-1], carry_ff});
      end

      bit_b = lvl2[GRAY_W-1];
      // level - 255 wraps to level + 1 in eight bits
      err_b = bit_b ? $signed(lvl2 + 8'd1) : $signed(lvl2);
      e12   = {{(12 - ERR_W){err_b[ERR_W-1]}}, err_b};
      d1    = div16(e12);
      d3    = div16(e12 + (e12 <<< 1));
      d5    = div16(e12 + (e12 <<< 2));
      d7    = div16((e12 <<< 3) - e12);

      acc_left_in = acc_here_ff + d5;
      w1_valid    = valid_b_ff && (col_b_ff != '0);
      w1_data     = acc_left_ff + d3;

      ram_we = pend_valid_ff || w1_valid;
      if (pend_valid_ff) begin
         ram_wa = pend_addr_ff;
         ram_wd = pend_data_ff;
      end else begin
         ram_wa = col_b_ff - 1'b1;
         ram_wd = w1_data;
      end

      rsp_in.pixel_bit = bit_b ^ invert_ff;
      rsp_in.line_end  = last_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff      <= '0;
         acc_left_ff   <= '0;
         acc_here_ff   <= '0;
         pend_valid_ff <= 1'b0;
         fill_ff       <= '0;
      end else begin
         pend_valid_ff <= valid_b_ff && last_b_ff;
         if (ram_we && ({1'b0, ram_wa} == fill_ff)) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (valid_b_ff) begin
            if (last_b_ff) begin
               carry_ff    <= '0;
               acc_left_ff <= '0;
               acc_here_ff <= '0;
            end else begin
               carry_ff    <= d7[CARRY_W-1:0];
               acc_left_ff <= acc_left_in;
               acc_here_ff <= d1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (valid_b_ff && last_b_ff) begin
         pend_addr_ff <= col_b_ff;
         pend_data_ff <= acc_left_in;
      end
   end

   // ---------------------------------------------------------- output queue
   assign push       = valid_b_ff;
   assign rsp_tvalid = (occ_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tdata  = {{(RSP_TDATA_W - 1){1'b0}}, head.pixel_bit};
   assign rsp_tlast  = head.line_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            occ_ff <= occ_ff + 1'b1;
         end else if (pop && !push) begin
            occ_ff <= occ_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

`default_nettype wire

[rtl/edh_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle; read returns old data.
// ----------------------------------------------------------------------------
`default_nettype none

module edh_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 2048,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/edh_checker.sv]
// ----------------------------------------------------------------------------
// Error diffusion halftoner port checker
// Watches the stream ports of the halftoner over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "error_diffusion_halftoner_defines.svh"

module edh_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [edh_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tlast
);

   `EDH_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result item changed")
   `EDH_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid right after reset")
   `EDH_ASSERT(a_rsp_from_req, $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2), "result item without an input item two cycles earlier")
   `EDH_ASSERT(a_stall_backlog, !req_tready |-> rsp_tvalid, "input stalled with no result waiting")

endmodule

bind error_diffusion_halftoner edh_checker u_edh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
